// ----- rtl/core/dhd_pkg.sv -----
// dhd_pkg: shared types and constants for the der header decoder
// word structs for the byte and result channels, status codes, limits
// no dependencies
package dhd_pkg;

    localparam int MAX_TAG_BYTES = 4;
    localparam int MAX_LEN_BYTES = 4;

    localparam int TAG_W     = 28;
    localparam int LEN_W     = 32;
    localparam int SIZE_W    = 4;
    localparam int TAG_CNT_W = $clog2(MAX_TAG_BYTES + 1);
    localparam int LEN_CNT_W = $clog2(MAX_LEN_BYTES + 1);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TRUNC   = 2'd1,
        ST_TAG_OVF = 2'd2,
        ST_LEN_BIG = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_header;
        logic       buffer_end;
    } in_word_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [1:0]        tag_class;
        logic              constructed;
        logic [TAG_W-1:0]  tag_number;
        logic [LEN_W-1:0]  length_value;
        logic              indefinite;
        logic [SIZE_W-1:0] header_size;
    } out_word_t;

endpackage

// ----- rtl/core/der_header_decoder.sv -----
// der_header_decoder: byte-serial ASN.1 identifier and length header parser
// the result word is registered when its completing byte leaves the input register
// throughput: one byte per cycle; the input register advances into the parser
// whenever the result register is empty or being taken
// reset: synchronous active-low aresetn clears both valid flags and the parse state to idle
// depends on dhd_pkg, dhd_parser
module der_header_decoder
    import dhd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_word,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word
);

    logic      in_valid_reg;
    in_word_t  in_word_reg;
    logic      out_valid_reg;
    out_word_t out_word_reg;

    logic      advance;
    logic      emit;
    out_word_t res_word;

    // the held byte moves on once the result slot can take whatever it produces
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_word  = out_word_reg;

    dhd_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (advance),
        .in_word  (in_word_reg),
        .emit     (emit),
        .res_word (res_word)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance && emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_word;
        end
        if (advance && emit) begin
            out_word_reg <= res_word;
        end
    end

endmodule

// ----- rtl/core/dhd_parser.sv -----
// dhd_parser: header parse state and its per-byte update
// holds the identifier/length state machine, gives one result word per finished header
// depends on dhd_pkg
module dhd_parser
    import dhd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step,
    input  in_word_t  in_word,
    output logic      emit,
    output out_word_t res_word
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TAG_LONG,
        PH_LEN_FIRST,
        PH_LEN_LONG
    } phase_t;

    phase_t                phase_reg,     phase_next;
    logic [1:0]            class_reg,     class_next;
    logic                  cons_reg,      cons_next;
    logic [TAG_W-1:0]      tag_reg,       tag_next;
    logic [TAG_CNT_W-1:0]  tag_cnt_reg,   tag_cnt_next;
    logic [LEN_W-1:0]      len_reg,       len_next;
    logic [LEN_CNT_W-1:0]  left_reg,      left_next;
    logic [SIZE_W-1:0]     bytes_reg,     bytes_next;

    logic [7:0]            b;
    logic [SIZE_W-1:0]     bytes_inc;
    logic [LEN_CNT_W-1:0]  left_dec;
    status_t               status;
    logic                  indef;
    logic                  ok;

    assign b         = in_word.data_byte;
    assign bytes_inc = (bytes_reg == {SIZE_W{1'b1}}) ? bytes_reg : bytes_reg + 1'b1;
    assign left_dec  = (left_reg != '0) ? left_reg - 1'b1 : left_reg;

    always_comb begin
        phase_next   = phase_reg;
        class_next   = class_reg;
        cons_next    = cons_reg;
        tag_next     = tag_reg;
        tag_cnt_next = tag_cnt_reg;
        len_next     = len_reg;
        left_next    = left_reg;
        bytes_next   = bytes_reg;
        emit         = 1'b0;
        status       = ST_OK;
        indef        = 1'b0;

        if (in_word.start_header) begin
            class_next   = b[7:6];
            cons_next    = b[5];
            tag_cnt_next = '0;
            len_next     = '0;
            left_next    = '0;
            bytes_next   = SIZE_W'(1);
            if (b[4:0] == 5'h1f) begin
                tag_next   = '0;
                phase_next = PH_TAG_LONG;
            end else begin
                tag_next   = TAG_W'(b[4:0]);
                phase_next = PH_LEN_FIRST;
            end
            if (in_word.buffer_end) begin
                emit   = 1'b1;
                status = ST_TRUNC;
            end
        end else begin
            case (phase_reg)
                PH_TAG_LONG: begin
                    bytes_next = bytes_inc;
                    if (tag_cnt_reg >= TAG_CNT_W'(MAX_TAG_BYTES) ||
                        tag_reg[TAG_W-1:TAG_W-7] != '0) begin
                        emit   = 1'b1;
                        status = ST_TAG_OVF;
                    end else begin
                        tag_cnt_next = tag_cnt_reg + 1'b1;
                        tag_next     = {tag_reg[TAG_W-8:0], b[6:0]};
                        if (!b[7]) begin
                            phase_next = PH_LEN_FIRST;
                        end
                        if (in_word.buffer_end) begin
                            emit   = 1'b1;
                            status = ST_TRUNC;
                        end
                    end
                end
                PH_LEN_FIRST: begin
                    bytes_next = bytes_inc;
                    if (b == 8'h80) begin
                        len_next = '0;
                        emit     = 1'b1;
                        indef    = 1'b1;
                    end else if (!b[7]) begin
                        len_next = LEN_W'(b);
                        emit     = 1'b1;
                    end else if (b[6:0] > 7'(MAX_LEN_BYTES)) begin
                        emit   = 1'b1;
                        status = ST_LEN_BIG;
                    end else begin
                        len_next   = '0;
                        left_next  = LEN_CNT_W'(b[6:0]);
                        phase_next = PH_LEN_LONG;
                        if (in_word.buffer_end) begin
                            emit   = 1'b1;
                            status = ST_TRUNC;
                        end
                    end
                end
                PH_LEN_LONG: begin
                    bytes_next = bytes_inc;
                    if (len_reg[LEN_W-1:LEN_W-8] != '0) begin
                        emit   = 1'b1;
                        status = ST_LEN_BIG;
                    end else begin
                        len_next  = {len_reg[LEN_W-9:0], b};
                        left_next = left_dec;
                        if (left_dec == '0) begin
                            emit = 1'b1;
                        end else if (in_word.buffer_end) begin
                            emit   = 1'b1;
                            status = ST_TRUNC;
                        end
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        if (emit) begin
            phase_next = PH_IDLE;
        end
    end

    // result fields come from the updated state
    assign ok = (status == ST_OK);

    always_comb begin
        res_word.status       = status;
        res_word.tag_class    = class_next;
        res_word.constructed  = cons_next;
        res_word.tag_number   = ok ? tag_next : '0;
        res_word.length_value = (ok && !indef) ? len_next : '0;
        res_word.indefinite   = ok && indef;
        res_word.header_size  = bytes_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            class_reg   <= '0;
            cons_reg    <= 1'b0;
            tag_reg     <= '0;
            tag_cnt_reg <= '0;
            len_reg     <= '0;
            left_reg    <= '0;
            bytes_reg   <= '0;
        end else if (step) begin
            phase_reg   <= phase_next;
            class_reg   <= class_next;
            cons_reg    <= cons_next;
            tag_reg     <= tag_next;
            tag_cnt_reg <= tag_cnt_next;
            len_reg     <= len_next;
            left_reg    <= left_next;
            bytes_reg   <= bytes_next;
        end
    end

endmodule

// ----- tb/sv/der_header_decoder_tb.sv -----
`timescale 1ns / 1ps
// der_header_decoder_tb: self-checking bench for the byte-serial der header decoder
// predicts each header from the accepted bytes and checks the result words in order
// depends on dhd_pkg and der_header_decoder
module der_header_decoder_tb;
    import dhd_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_BYTES = 2000;
    localparam int HOLD_CYCLES  = 300;

    localparam int RX_OPEN    = 0;
    localparam int RX_RANDOM  = 1;
    localparam int RX_PATTERN = 2;

    typedef enum int {
        PARSE_IDLE,
        PARSE_TAG,
        PARSE_LEN_FIRST,
        PARSE_LEN_LONG
    } parse_phase_t;

    typedef logic [7:0] byte_q_t[$];

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_word  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_word;

    der_header_decoder dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_word (s_word),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_word (m_word)
    );

    always #5 aclk = ~aclk;

    // header parse state as the block should hold it
    parse_phase_t      hdr_phase      = PARSE_IDLE;
    logic [1:0]        id_class       = '0;
    logic              id_constructed = 1'b0;
    logic [TAG_W-1:0]  tag_acc        = '0;
    int                tag_bytes      = 0;
    logic [LEN_W-1:0]  len_acc        = '0;
    int                len_left       = 0;
    logic [SIZE_W-1:0] hdr_bytes      = '0;

    out_word_t pending_headers[$];
    out_word_t got_header;
    out_word_t want_header;
    int        mismatches = 0;

    bit pace_on    = 1'b1;
    int burst_left = 0;
    int hold_req   = 0;
    int hold_left  = 0;
    int rx_mode    = RX_OPEN;
    int mode_left  = 0;
    int rx_tick    = 0;
    int stall_cycles;

    task automatic close_header(input status_t st, input bit indef);
        out_word_t w;
        bit ok;
        ok            = (st == ST_OK);
        w.status      = st;
        w.tag_class   = id_class;
        w.constructed = id_constructed;
        w.tag_number  = ok ? tag_acc : '0;
        w.length_value = (ok && !indef) ? len_acc : '0;
        w.indefinite  = ok && indef;
        w.header_size = hdr_bytes;
        pending_headers = {pending_headers, w};
        hdr_phase = PARSE_IDLE;
    endtask

    task automatic parse_byte(input in_word_t w);
        logic [7:0] b;
        b = w.data_byte;
        if (w.start_header) begin
            id_class       = b[7:6];
            id_constructed = b[5];
            tag_bytes      = 0;
            len_acc        = '0;
            len_left       = 0;
            hdr_bytes      = 4'd1;
            if (b[4:0] == 5'h1f) begin
                tag_acc   = '0;
                hdr_phase = PARSE_TAG;
            end else begin
                tag_acc   = TAG_W'(b[4:0]);
                hdr_phase = PARSE_LEN_FIRST;
            end
            if (w.buffer_end)
                close_header(ST_TRUNC, 1'b0);
        end else if (hdr_phase != PARSE_IDLE) begin
            if (hdr_bytes != 4'd15)
                hdr_bytes++;
            case (hdr_phase)
                PARSE_TAG: begin
                    if (tag_bytes >= MAX_TAG_BYTES || tag_acc[TAG_W-1:21] != 0) begin
                        close_header(ST_TAG_OVF, 1'b0);
                    end else begin
                        tag_bytes++;
                        tag_acc = {tag_acc[20:0], b[6:0]};
                        if (!b[7])
                            hdr_phase = PARSE_LEN_FIRST;
                        if (w.buffer_end)
                            close_header(ST_TRUNC, 1'b0);
                    end
                end
                PARSE_LEN_FIRST: begin
                    if (b == 8'h80) begin
                        len_acc = '0;
                        close_header(ST_OK, 1'b1);
                    end else if (!b[7]) begin
                        len_acc = LEN_W'(b);
                        close_header(ST_OK, 1'b0);
                    end else if (int'(b[6:0]) > MAX_LEN_BYTES) begin
                        close_header(ST_LEN_BIG, 1'b0);
                    end else begin
                        len_acc   = '0;
                        len_left  = int'(b[6:0]);
                        hdr_phase = PARSE_LEN_LONG;
                        if (w.buffer_end)
                            close_header(ST_TRUNC, 1'b0);
                    end
                end
                default: begin
                    if (len_acc[LEN_W-1:24] != 0) begin
                        close_header(ST_LEN_BIG, 1'b0);
                    end else begin
                        len_acc = {len_acc[23:0], b};
                        if (len_left > 0)
                            len_left--;
                        if (len_left == 0)
                            close_header(ST_OK, 1'b0);
                        else if (w.buffer_end)
                            close_header(ST_TRUNC, 1'b0);
                    end
                end
            endcase
        end
    endtask

    // drive one word, hold it until taken, then maybe open a gap
    task automatic send_byte(input logic [7:0] b, input bit first, input bit last);
        in_word_t w;
        int gap;
        w.data_byte    = b;
        w.start_header = first;
        w.buffer_end   = last;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_word  <= w;
        do
            @(posedge aclk);
        while (!s_ready);
        parse_byte(w);
        if (pace_on) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 8);
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
                burst_left = $urandom_range(1, 16);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_header(input byte_q_t bytes, input bit end_on_last);
        int i;
        for (i = 0; i < bytes.size(); i++)
            send_byte(bytes[i], i == 0, end_on_last && i == bytes.size() - 1);
    endtask

    task automatic wait_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_headers.size() != 0)
            @(posedge aclk);
    endtask

    task automatic test_short_headers();
        send_header({8'h00, 8'h00}, 1'b0);
        // private constructed tag 30, indefinite length
        send_header({8'hfe, 8'h80}, 1'b1);
        send_header({8'h9d, 8'h7f}, 1'b0);
        wait_results();
    endtask

    task automatic test_long_headers();
        // widest tag and widest length, ten header bytes
        send_header({8'h3f, 8'hff, 8'hff, 8'hff, 8'h7f,
                     8'h84, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b0);
        wait_results();
    endtask

    task automatic test_error_cases();
        // zero digits fill the tag count, the next tag byte overflows
        send_header({8'h1f, 8'h80, 8'h80, 8'h80, 8'h80, 8'h01}, 1'b0);
        send_header({8'h02, 8'h85}, 1'b0);
        send_header({8'h04, 8'h82, 8'h01}, 1'b1);
        wait_results();
    endtask

    task automatic test_stray_bytes();
        send_byte(8'h55, 1'b0, 1'b0);
        // abandoned long tag, then a restart cut off at its identifier
        send_byte(8'h1f, 1'b1, 1'b0);
        send_byte(8'h30, 1'b1, 1'b1);
        wait_results();
    endtask

    task automatic test_backpressure();
        int i;
        pace_on  = 1'b0;
        hold_req = HOLD_CYCLES;
        for (i = 0; i < 30; i++)
            send_header({{2'($urandom), 1'($urandom), 5'($urandom_range(0, 30))},
                         {1'b0, 7'($urandom)}}, 1'b0);
        wait_results();
        pace_on = 1'b1;
    endtask

    task automatic send_random_header(inout int sent);
        byte_q_t hdr;
        logic [7:0] id;
        logic [7:0] lb;
        int n_tag, n_len, cut_at, i;
        bit end_cut;
        // stray words outside a header
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3))
                send_byte(8'($urandom), 1'b0, 1'($urandom));
        id = 8'($urandom);
        if ($urandom_range(0, 2) == 0)
            id[4:0] = 5'h1f;
        hdr = {hdr, id};
        if (id[4:0] == 5'h1f) begin
            n_tag = ($urandom_range(0, 15) == 0) ? MAX_TAG_BYTES + 1
                                                 : $urandom_range(1, MAX_TAG_BYTES);
            for (i = 0; i < n_tag; i++) begin
                lb[6:0] = ($urandom_range(0, 3) == 0) ? 7'h00 : 7'($urandom);
                lb[7]   = (i != n_tag - 1);
                hdr = {hdr, lb};
            end
        end
        case ($urandom_range(0, 7))
            0: hdr = {hdr, 8'h80};
            1, 2, 3: hdr = {hdr, {1'b0, 7'($urandom)}};
            7: hdr = {hdr, {1'b1, 7'($urandom_range(MAX_LEN_BYTES + 1, 127))}};
            default: begin
                n_len = $urandom_range(1, MAX_LEN_BYTES);
                hdr = {hdr, 8'h80 | 8'(n_len)};
                for (i = 0; i < n_len; i++)
                    hdr = {hdr, ($urandom_range(0, 5) == 0) ? 8'hff : 8'($urandom)};
            end
        endcase
        cut_at  = hdr.size() - 1;
        end_cut = 1'($urandom);
        case ($urandom_range(0, 11))
            0: begin
                cut_at  = $urandom_range(0, hdr.size() - 1);
                end_cut = 1'b1;
            end
            // left unfinished so the next identifier restarts the parse
            1: begin
                cut_at  = $urandom_range(0, hdr.size() - 1);
                end_cut = 1'b0;
            end
            default: ;
        endcase
        hdr = hdr[0:cut_at];
        send_header(hdr, end_cut);
        sent += hdr.size();
    endtask

    task automatic test_random_headers();
        int sent;
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            if ($urandom_range(0, 39) == 0)
                pace_on = !pace_on;
            send_random_header(sent);
        end
        pace_on = 1'b1;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_header = m_word;
            if (pending_headers.size() == 0) begin
                $error("result word with no header pending");
                mismatches++;
            end else begin
                want_header = pending_headers.pop_front();
                check_field("status", 32'(want_header.status), 32'(got_header.status));
                check_field("tag_class", 32'(want_header.tag_class),
                            32'(got_header.tag_class));
                check_field("constructed", 32'(want_header.constructed),
                            32'(got_header.constructed));
                check_field("tag_number", 32'(want_header.tag_number),
                            32'(got_header.tag_number));
                check_field("length_value", want_header.length_value,
                            got_header.length_value);
                check_field("indefinite", 32'(want_header.indefinite),
                            32'(got_header.indefinite));
                check_field("header_size", 32'(want_header.header_size),
                            32'(got_header.header_size));
            end
        end
    end

    // result side: long hold on request, otherwise open, random or patterned stalls
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = $urandom_range(RX_OPEN, RX_PATTERN);
                    mode_left = $urandom_range(20, 200);
                end else begin
                    mode_left--;
                end
                case (rx_mode)
                    RX_OPEN:   m_ready <= 1'b1;
                    RX_RANDOM: m_ready <= 1'($urandom);
                    default:   m_ready <= (rx_tick % 7) < 3;
                endcase
                rx_tick++;
            end
        end
    end

    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_short_headers();
        test_long_headers();
        test_error_cases();
        test_stray_bytes();
        test_backpressure();
        test_random_headers();
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_headers.size() != 0) begin
            $error("%0d headers never came out", pending_headers.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
